FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/ragcs_pkg.sv
// ----------------------------------------------------------------------------
// ragcs_pkg
// Shared widths, defaults and types of the rotating angle cos/sin generator.
// ----------------------------------------------------------------------------
package ragcs_pkg;

  localparam int TURN_RATE_W = 24;
  localparam int TIME_STEP_W = 18;
  localparam int PROD_W      = TURN_RATE_W + TIME_STEP_W + 1;
  localparam int SAMPLE_W    = 16;
  localparam int ANGLE_W     = 16;
  localparam int TABLE_W     = 15;

  localparam int QUARTER_TABLE_DEPTH_DEF = 256;
  localparam int PHASE_BITS_DEF          = 32;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [TABLE_W-1:0] TABLE_MAX = {TABLE_W{1'b1}};

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  typedef struct packed {
    logic accept;
    logic advance;
    logic cfg_write;
  } phase_ctrl_t;

  typedef struct packed {
    logic load;
    logic take;
  } lut_ctrl_t;

endpackage

FILE: sv/rotating_angle_cos_sin_generator.sv
// ----------------------------------------------------------------------------
// rotating_angle_cos_sin_generator
// Quadrature oscillator: accumulates turn rate times step, emits cos and sin.
// ----------------------------------------------------------------------------
// Takes one time step per clock while in_stall_o is low and returns cos, sin
// (Q1.15) and the top 16 phase bits. The phase accumulator's single
// multiply-add per item sets the rate of one item per cycle unless stalled;
// the sine table lookup sits in the second stage. The phase register lets a
// new step enter while out_stall_i holds a result. QUARTER_TABLE_DEPTH must
// be a power of two. Write the turn rate only while no item is in flight.
`include "assert_macros.svh"

module rotating_angle_cos_sin_generator import ragcs_pkg::*; #(
  parameter int QUARTER_TABLE_DEPTH = QUARTER_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS          = PHASE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [TURN_RATE_W-1:0]     cfg_turn_rate_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [TIME_STEP_W-1:0]     time_step_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] cos_value_o,
  output logic signed [SAMPLE_W-1:0] sin_value_o,
  output logic [ANGLE_W-1:0]         angle_out_o
);

  phase_ctrl_t           phase_ctrl;
  lut_ctrl_t             lut_ctrl;
  logic [PHASE_BITS-1:0] phase;
  logic                  phase_valid;
  logic                  out_free;

  assign out_free    = ~out_valid_o | ~out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = phase_valid & ~out_free;

  assign phase_ctrl.accept    = in_valid_i & ~in_stall_o;
  assign phase_ctrl.advance   = phase_valid & out_free;
  assign phase_ctrl.cfg_write = cfg_valid_i & cfg_ready_o;

  assign lut_ctrl.load = phase_valid & out_free;
  assign lut_ctrl.take = out_valid_o & ~out_stall_i;

  ragcs_phase_acc #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (phase_ctrl),
    .turn_rate_i (cfg_turn_rate_i),
    .time_step_i (time_step_i),
    .phase_o     (phase),
    .valid_o     (phase_valid)
  );

  ragcs_sine_lut #(
    .QUARTER_TABLE_DEPTH (QUARTER_TABLE_DEPTH),
    .PHASE_BITS          (PHASE_BITS)
  ) u_sine_lut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lut_ctrl),
    .phase_i (phase),
    .cos_o   (cos_value_o),
    .sin_o   (sin_value_o),
    .angle_o (angle_out_o),
    .valid_o (out_valid_o)
  );

  `ASSERT_CLK(a_stall_only_when_blocked, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled while output free")
  `ASSERT_CLK(a_pending_moves_on, clk_i, rst_ni, (phase_valid && !out_valid_o) |=> out_valid_o, "pending item not passed to output")
  `ASSERT_CLK(a_angle_from_phase, clk_i, rst_ni, lut_ctrl.load |=> (angle_out_o == $past(phase[PHASE_BITS-1 -: ANGLE_W])), "angle does not match phase")

endmodule

FILE: sv/ragcs_phase_acc.sv
// ----------------------------------------------------------------------------
// ragcs_phase_acc
// Turn rate register and phase accumulator: adds rate times step per item.
// ----------------------------------------------------------------------------
module ragcs_phase_acc import ragcs_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  phase_ctrl_t            ctrl_i,
  input  logic [TURN_RATE_W-1:0] turn_rate_i,
  input  logic [TIME_STEP_W-1:0] time_step_i,
  output logic [PHASE_BITS-1:0]  phase_o,
  output logic                   valid_o
);

  localparam int EXT_W = PROD_W + PHASE_BITS;

  logic [TURN_RATE_W-1:0]    rate_q;
  logic [PHASE_BITS-1:0]     phase_q, phase_d;
  logic                      valid_q, valid_d;
  logic signed [PROD_W-1:0]  prod;
  logic signed [EXT_W-1:0]   prod_ext;
  logic signed [EXT_W-1:0]   inc_ext;
  logic [PHASE_BITS-1:0]     inc;

  assign prod     = PROD_W'($signed(rate_q)) * PROD_W'($signed({1'b0, time_step_i}));
  assign prod_ext = EXT_W'(prod);

  generate
    if (PHASE_BITS >= 32) begin : g_shl
      assign inc_ext = prod_ext <<< (PHASE_BITS - 32);
    end else begin : g_shr
      assign inc_ext = prod_ext >>> (32 - PHASE_BITS);
    end
  endgenerate

  assign inc     = inc_ext[PHASE_BITS-1:0];
  assign phase_d = phase_q + inc;
  assign valid_d = ctrl_i.accept | (valid_q & ~ctrl_i.advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= '0;
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctrl_i.cfg_write) begin
        rate_q <= turn_rate_i;
      end
      if (ctrl_i.accept) begin
        phase_q <= phase_d;
      end
      valid_q <= valid_d;
    end
  end

  assign phase_o = phase_q;
  assign valid_o = valid_q;

endmodule

FILE: sv/ragcs_sine_lut.sv
// ----------------------------------------------------------------------------
// ragcs_sine_lut
// Quarter-wave sine table with quadrant folding and the result register.
// ----------------------------------------------------------------------------
module ragcs_sine_lut import ragcs_pkg::*; #(
  parameter int QUARTER_TABLE_DEPTH = QUARTER_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS          = PHASE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lut_ctrl_t                  ctrl_i,
  input  logic [PHASE_BITS-1:0]      phase_i,
  output logic signed [SAMPLE_W-1:0] cos_o,
  output logic signed [SAMPLE_W-1:0] sin_o,
  output logic [ANGLE_W-1:0]         angle_o,
  output logic                       valid_o
);

  localparam int DEPTH_LOG = $clog2(QUARTER_TABLE_DEPTH);
  localparam int IDX_W     = DEPTH_LOG + 1;
  localparam logic [63:0] TWO_DEPTH = 64'(2 * QUARTER_TABLE_DEPTH);
  localparam logic [63:0] DEPTH_64  = 64'(QUARTER_TABLE_DEPTH);

  typedef logic [QUARTER_TABLE_DEPTH:0][TABLE_W-1:0] tab_t;

  function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] r;
    r = (t * x) >> 30;
    r = (r * x) >> 30;
    return r;
  endfunction

  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = x;
    sum  = x;
    term = sq_step(term, x) / 64'd6;   sum = sum - term;
    term = sq_step(term, x) / 64'd20;  sum = sum + term;
    term = sq_step(term, x) / 64'd42;  sum = sum - term;
    term = sq_step(term, x) / 64'd72;  sum = sum + term;
    term = sq_step(term, x) / 64'd110; sum = sum - term;
    term = sq_step(term, x) / 64'd156; sum = sum + term;
    term = sq_step(term, x) / 64'd210; sum = sum - term;
    term = sq_step(term, x) / 64'd272; sum = sum + term;
    return sum;
  endfunction

  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] x;
    logic [63:0] s;
    for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
      x = (64'(k) * PI_Q30 + DEPTH_64) / TWO_DEPTH;
      s = (sine_q30(x) + 64'd16384) >> 15;
      if (s > 64'(TABLE_MAX)) begin
        s = 64'(TABLE_MAX);
      end
      t[k] = s[TABLE_W-1:0];
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [DEPTH_LOG-1:0]       pos;
  logic [IDX_W-1:0]           pos_idx, cmp_idx;
  logic signed [SAMPLE_W-1:0] a_s, b_s;
  logic signed [SAMPLE_W-1:0] cos_d, sin_d, cos_q, sin_q;
  logic [ANGLE_W-1:0]         angle_q;
  logic                       valid_q, valid_d;
  quad_e                      quad;

  assign quad    = quad_e'(phase_i[PHASE_BITS-1 -: 2]);
  assign pos     = phase_i[PHASE_BITS-3 -: DEPTH_LOG];
  assign pos_idx = IDX_W'(pos);
  assign cmp_idx = IDX_W'(QUARTER_TABLE_DEPTH) - pos_idx;
  assign a_s     = $signed(SAMPLE_W'(SINE_TAB[pos_idx]));
  assign b_s     = $signed(SAMPLE_W'(SINE_TAB[cmp_idx]));

  always_comb begin
    case (quad)
      QUAD_I: begin
        cos_d = b_s;
        sin_d = a_s;
      end
      QUAD_II: begin
        cos_d = -a_s;
        sin_d = b_s;
      end
      QUAD_III: begin
        cos_d = -b_s;
        sin_d = -a_s;
      end
      default: begin
        cos_d = a_s;
        sin_d = -b_s;
      end
    endcase
  end

  assign valid_d = ctrl_i.load | (valid_q & ~ctrl_i.take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cos_q   <= cos_d;
      sin_q   <= sin_d;
      angle_q <= phase_i[PHASE_BITS-1 -: ANGLE_W];
    end
  end

  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign angle_o = angle_q;
  assign valid_o = valid_q;

endmodule
